// ===== hdl/cts_pkg.sv =====
// Package for the circle track smoother: item and result structs, field widths
// and the fixed-point blend function.
// No dependencies; used by circle_track_smoother.
package cts_pkg;

	localparam int COORD_W = 16;
	localparam int ENTRY_W = 3 * COORD_W;

	// Blend weights: about 0.2 of the new value and 0.8 of the stored one, in 1/256.
	localparam logic [7:0] BLEND_CUR  = 8'd51;
	localparam logic [7:0] BLEND_PREV = 8'd205;
	localparam logic [7:0] BLEND_RND  = 8'd128;

	typedef struct packed {
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [COORD_W-1:0] radius;
		logic               frame_empty;
		logic               last_in_frame;
	} item_t;

	typedef struct packed {
		logic [COORD_W-1:0] out_x;
		logic [COORD_W-1:0] out_y;
		logic [COORD_W-1:0] out_r;
		logic               circle_valid;
		logic               matched;
		logic               blended;
		logic [COORD_W-1:0] miss_count;
		logic               frame_done;
	} result_t;

	function automatic logic [COORD_W-1:0] absdiff(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b);
		absdiff = (a > b) ? (a - b) : (b - a);
	endfunction

	// The weighted sum stays below 2**24, so bits 23:8 are the rounded result.
	function automatic logic [COORD_W-1:0] blend(input logic [COORD_W-1:0] cur,
			input logic [COORD_W-1:0] prev);
		logic [23:0] sum;
		sum = 24'(cur) * 24'(BLEND_CUR) + 24'(prev) * 24'(BLEND_PREV) + 24'(BLEND_RND);
		blend = sum[23:8];
	endfunction

endpackage

// ===== hdl/cts_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies; used by circle_track_smoother for the circle lists.
module cts_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hdl/circle_track_smoother.sv =====
// Circle track smoother: one circle in, one smoothed circle out; uses cts_pkg and cts_ram.
// An empty-frame item, or one that meets an empty previous list, goes straight to the store step;
// otherwise each stored circle searched takes DX, DY, M and CMP, then a blend if one applies, then the store.
// A new item is taken only in idle, after the store of the last one, which waits while a result is held;
// the search is sequential, as the single squaring multiplier is shared across each compare.
// Reset clears the list counts, bank select, miss counter, sequencer and result valid; the RAM is not cleared.
module circle_track_smoother #(
	parameter int MAX_CIRCLES = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  cts_pkg::item_t  item,
	output logic            result_valid,
	input  logic            result_ready,
	output cts_pkg::result_t result
);

	// Count width holds MAX_CIRCLES itself; the index addresses entries within a bank.
	localparam int CW = $clog2(MAX_CIRCLES + 1);
	localparam int IW = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
	localparam int AW = IW + 1;
	localparam int DEPTH = 2 ** AW;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_CIRCLES);

	// Sequencer states. One stored circle takes DX, DY, M and CMP.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DX   = 3'd1;
	localparam logic [2:0] S_DY   = 3'd2;
	localparam logic [2:0] S_M    = 3'd3;
	localparam logic [2:0] S_CMP  = 3'd4;
	localparam logic [2:0] S_BL   = 3'd5;
	localparam logic [2:0] S_WR   = 3'd6;

	logic [2:0] state_q;

	// Current item, overwritten by the blend when one applies.
	logic [15:0] x_q, y_q, r_q;
	logic        empty_q, last_q, matched_q, blended_q;

	// Stored circle under test and the partial results of the distance test.
	logic [cts_pkg::ENTRY_W-1:0] pe_q;
	logic [15:0] m_q;
	logic [32:0] acc_q;
	logic [31:0] msq_q;
	logic [IW-1:0] idx_q;

	// List bookkeeping. bank_q names the bank that holds the previous frame's list.
	logic [CW-1:0] prev_cnt_q, cur_cnt_q;
	logic          bank_q;
	logic [15:0]   miss_q;

	logic                        res_valid_q;
	cts_pkg::result_t            res_q;

	logic                        rd_en, wr_en;
	logic [AW-1:0]               rd_addr, wr_addr;
	logic [cts_pkg::ENTRY_W-1:0] rd_data, wr_data;

	logic        accept, out_free, finish;
	logic [15:0] mul_op;
	logic [31:0] prod;
	logic [15:0] px, py, pr;
	logic        near, radius_ok, more;
	logic [36:0] dist16, m9;
	logic [17:0] dr4, m3;
	logic [CW-1:0] nxt_cnt;

	assign item_ready   = (state_q == S_IDLE);
	assign accept       = item_valid && item_ready;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// The result register frees up in the same cycle that its transfer completes.
	assign out_free = !res_valid_q || result_ready;
	assign finish   = (state_q == S_WR) && out_free;

	// Stored entries pack x in the low field, then y, then r.
	assign px = pe_q[15:0];
	assign py = pe_q[31:16];
	assign pr = pe_q[47:32];

	// The one shared multiplier squares dx, then dy, then the larger radius.
	always_comb begin
		case (state_q)
			S_DX:    mul_op = cts_pkg::absdiff(x_q, rd_data[15:0]);
			S_DY:    mul_op = cts_pkg::absdiff(y_q, py);
			S_M:     mul_op = m_q;
			default: mul_op = '0;
		endcase
	end
	assign prod = 32'(mul_op) * 32'(mul_op);

	// Center test 16*(dx^2+dy^2) < 9*m^2 and radius test 4*|r-pr| < 3*m.
	assign dist16    = {acc_q, 4'b0000};
	assign m9        = {2'b00, msq_q, 3'b000} + {5'b00000, msq_q};
	assign near      = dist16 < m9;
	assign dr4       = {cts_pkg::absdiff(r_q, pr), 2'b00};
	assign m3        = {1'b0, m_q, 1'b0} + {2'b00, m_q};
	assign radius_ok = dr4 < m3;

	// Another stored circle remains after the one under test.
	assign nxt_cnt = CW'(idx_q) + CW'(1);
	assign more    = nxt_cnt < prev_cnt_q;

	// Reads go to the previous bank: the first entry at accept, the next one on a miss.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = {bank_q, idx_q + IW'(1)};
		if (state_q == S_IDLE) begin
			rd_addr = {bank_q, {IW{1'b0}}};
			rd_en   = accept && !item.frame_empty && (prev_cnt_q != '0);
		end else if (state_q == S_CMP) begin
			rd_en   = !near && more;
		end
	end

	// The emitted circle is appended to the other bank while room remains.
	assign wr_en   = finish && !empty_q && (cur_cnt_q < MAX_C);
	assign wr_addr = {~bank_q, cur_cnt_q[IW-1:0]};
	assign wr_data = {r_q, y_q, x_q};

	cts_ram #(
		.WIDTH(cts_pkg::ENTRY_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Sequencer and list bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prev_cnt_q  <= '0;
			cur_cnt_q   <= '0;
			bank_q      <= 1'b0;
			miss_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (rd_en) begin
							state_q <= S_DX;
						end else begin
							state_q <= S_WR;
						end
					end
				end
				S_DX:  state_q <= S_DY;
				S_DY:  state_q <= S_M;
				S_M:   state_q <= S_CMP;
				S_CMP: begin
					if (near) begin
						state_q <= radius_ok ? S_BL : S_WR;
					end else if (more) begin
						state_q <= S_DX;
					end else begin
						state_q <= S_WR;
					end
				end
				S_BL:  state_q <= S_WR;
				S_WR: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (empty_q) begin
							// An empty frame drops both lists, including a partial frame.
							prev_cnt_q <= '0;
							cur_cnt_q  <= '0;
							if (miss_q != 16'hFFFF) begin
								miss_q <= miss_q + 16'd1;
							end
						end else begin
							miss_q <= '0;
							if (last_q) begin
								prev_cnt_q <= wr_en ? (cur_cnt_q + CW'(1)) : cur_cnt_q;
								cur_cnt_q  <= '0;
								bank_q     <= ~bank_q;
							end else if (wr_en) begin
								cur_cnt_q <= cur_cnt_q + CW'(1);
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers; they need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					x_q       <= item.pos_x;
					y_q       <= item.pos_y;
					r_q       <= item.radius;
					empty_q   <= item.frame_empty;
					last_q    <= item.last_in_frame;
					matched_q <= 1'b0;
					blended_q <= 1'b0;
					idx_q     <= '0;
				end
			end
			S_DX: begin
				pe_q  <= rd_data;
				m_q   <= (r_q > rd_data[47:32]) ? r_q : rd_data[47:32];
				acc_q <= {1'b0, prod};
			end
			S_DY:  acc_q <= acc_q + {1'b0, prod};
			S_M:   msq_q <= prod;
			S_CMP: begin
				if (near) begin
					// Only the first near circle counts; the search ends here.
					matched_q <= 1'b1;
					blended_q <= radius_ok;
				end else if (more) begin
					idx_q <= idx_q + IW'(1);
				end
			end
			S_BL: begin
				x_q <= cts_pkg::blend(x_q, px);
				y_q <= cts_pkg::blend(y_q, py);
				r_q <= cts_pkg::blend(r_q, pr);
			end
			default: begin
			end
		endcase

		if (finish) begin
			if (empty_q) begin
				res_q.out_x        <= '0;
				res_q.out_y        <= '0;
				res_q.out_r        <= '0;
				res_q.circle_valid <= 1'b0;
				res_q.matched      <= 1'b0;
				res_q.blended      <= 1'b0;
				res_q.miss_count   <= (miss_q != 16'hFFFF) ? (miss_q + 16'd1) : miss_q;
				res_q.frame_done   <= 1'b1;
			end else begin
				res_q.out_x        <= x_q;
				res_q.out_y        <= y_q;
				res_q.out_r        <= r_q;
				res_q.circle_valid <= 1'b1;
				res_q.matched      <= matched_q;
				res_q.blended      <= blended_q;
				res_q.miss_count   <= '0;
				res_q.frame_done   <= last_q;
			end
		end
	end

endmodule
